### sv/sps_pkg.sv
// Shared widths, types and saturation helpers for the S-parameter cascade block.
package sps_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 14;
  localparam int INNER_W   = 32;
  localparam int PROD_W    = 2 * INNER_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int QUO_W     = INNER_W - 1;
  localparam int DIV_STEPS = INNER_W + 2 * FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int TDATA_W   = 8 * SAMPLE_W;

  localparam logic signed [INNER_W-1:0]  INNER_MAX = {1'b0, {(INNER_W-1){1'b1}}};
  localparam logic signed [INNER_W-1:0]  INNER_MIN = {1'b1, {(INNER_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] ONE_SAMPLE = SAMPLE_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]    ONE_ACC    = ACC_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [INNER_W-1:0] re;
    logic signed [INNER_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic start;
    logic mag_mode;
  } cmul_ctrl_t;

  // Clamp a wide sum to the inner word
  function automatic logic signed [INNER_W-1:0] sat_inner(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-INNER_W){1'b0}}, INNER_MAX};
    lo = {{(ACC_W-INNER_W){1'b1}}, INNER_MIN};
    if (v > hi) return INNER_MAX;
    else if (v < lo) return INNER_MIN;
    else return v[INNER_W-1:0];
  endfunction

  // Clamp an inner-width sum to the sample word
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [INNER_W:0] v);
    logic signed [INNER_W:0] hi;
    logic signed [INNER_W:0] lo;
    hi = {{(INNER_W+1-SAMPLE_W){1'b0}}, SAMPLE_MAX};
    lo = {{(INNER_W+1-SAMPLE_W){1'b1}}, SAMPLE_MIN};
    if (v > hi) return SAMPLE_MAX;
    else if (v < lo) return SAMPLE_MIN;
    else return v[SAMPLE_W-1:0];
  endfunction

endpackage

### sv/sps_cmul.sv
// Complex multiplier built on one shared 32x32 real multiplier, four products per operation.
module sps_cmul import sps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmul_ctrl_t        ctrl,
  input  cplx_t             x,
  input  cplx_t             y,
  output logic              done,
  output cplx_t             p,
  output logic [MAG_W-1:0]  mag
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_BITS - 1));

  logic                     busy_r;
  logic [2:0]               ph_r;
  logic                     mode_r;
  logic                     done_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  re_r;
  logic signed [ACC_W-1:0]  im_r;
  logic signed [INNER_W-1:0] opa;
  logic signed [INNER_W-1:0] opb;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  term_rnd;
  logic signed [ACC_W-1:0]  term_raw;

  // Pick the operand pair for this phase: rr, ii, ri, ir
  always_comb begin
    case (ph_r[1:0])
      2'd0: begin opa = x.re; opb = y.re; end
      2'd1: begin opa = x.im; opb = y.im; end
      2'd2: begin opa = x.re; opb = y.im; end
      default: begin opa = x.im; opb = y.re; end
    endcase
  end

  // Round half up to the fraction bits
  assign prod_rnd = (prod_r + RND_HALF) >>> FRAC_BITS;
  assign term_rnd = {prod_rnd[PROD_W-1], prod_rnd};
  assign term_raw = {prod_r[PROD_W-1], prod_r};

  // Sequence the four products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Multiply and accumulate
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      re_r   <= '0;
      im_r   <= '0;
      mode_r <= ctrl.mag_mode;
    end else if (busy_r) begin
      prod_r <= opa * opb;
      case (ph_r)
        3'd1: re_r <= re_r + (mode_r ? term_raw : term_rnd);
        3'd2: re_r <= mode_r ? (re_r + term_raw) : (re_r - term_rnd);
        3'd3: im_r <= im_r + term_rnd;
        3'd4: im_r <= im_r + term_rnd;
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign p.re = sat_inner(re_r);
  assign p.im = sat_inner(im_r);
  assign mag  = re_r[MAG_W-1:0];

endmodule

### sv/sps_div.sv
// Restoring divider, one quotient bit a cycle, for the reciprocal parts.
module sps_div import sps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [INNER_W-1:0] num,
  input  logic [MAG_W-1:0]   den,
  output logic               done,
  output logic [QUO_W-1:0]   quo
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [INNER_W-1:0]    num_r;
  logic [MAG_W-1:0]      den_r;
  logic [MAG_W-1:0]      rem_r;
  logic [INNER_W-1:0]    q_r;
  logic                  ovf_r;
  logic [MAG_W-1:0]      rem_sh;
  logic                  ge;

  // Bring down the next numerator bit, then trial subtract
  assign rem_sh = {rem_r[MAG_W-2:0], num_r[INNER_W-1]};
  assign ge     = (rem_sh >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift numerator, remainder and quotient; keep a sticky overflow
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= {num_r[INNER_W-2:0], 1'b0};
      rem_r <= ge ? (rem_sh - den_r) : rem_sh;
      q_r   <= {q_r[INNER_W-2:0], ge};
      ovf_r <= ovf_r | q_r[INNER_W-1];
    end
  end

  assign done = done_r;
  assign quo  = (ovf_r || q_r[INNER_W-1]) ? {QUO_W{1'b1}} : q_r[QUO_W-1:0];

endmodule

### sv/s_parameter_cascade_star.sv
// Two-port S-parameter cascade by the star product, top level.
//
// Input channel (in_*): one stage per item, S11..S22 as signed Q2.14 words.
// in_tuser marks the first stage of a run: the accumulator restarts from the
// through connection. in_tlast marks the last stage: after it is combined,
// the cascaded matrix goes out on the result channel (out_*), with out_tuser
// set if any stage since the restart had an exactly zero denominator.
// Each item passes through the accepting step, eleven complex products of four
// real products each on one shared 32x32 multiplier, one magnitude product and
// two 60-step restoring divisions for the reciprocal, and the emit step when it
// emits. A zero denominator skips the magnitude product and the divisions.
// in_tready is high only when idle.
// Results sit in an output register; a stalled receiver holds it, and a
// following last stage waits in the emit step until that register frees.
// Reset loads the through connection and clears the singular flag; no
// result is pending after reset.
module s_parameter_cascade_star import sps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,  // s11_re, s11_im, s12_re, s12_im, s21_re, s21_im, s22_re, s22_im
  input  logic               in_tuser,  // first_stage
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata, // c11_re, c11_im, c12_re, c12_im, c21_re, c21_im, c22_re, c22_im
  output logic               out_tuser  // near_singular
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_MAG_GO, ST_MAG_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_EMIT
  } state_t;

  localparam logic [3:0] OP_PRE  = 4'd0;
  localparam logic [3:0] OP_T1   = 4'd1;
  localparam logic [3:0] OP_T2   = 4'd2;
  localparam logic [3:0] OP_C11  = 4'd3;
  localparam logic [3:0] OP_T4   = 4'd4;
  localparam logic [3:0] OP_C12  = 4'd5;
  localparam logic [3:0] OP_T6   = 4'd6;
  localparam logic [3:0] OP_C21  = 4'd7;
  localparam logic [3:0] OP_T8   = 4'd8;
  localparam logic [3:0] OP_T9   = 4'd9;
  localparam logic [3:0] OP_C22  = 4'd10;

  state_t                      state_r;
  logic [3:0]                  op_r;
  logic                        last_r;
  logic                        sing_r;
  logic                        div_im_r;
  logic signed [SAMPLE_W-1:0]  b_r   [8];
  logic signed [SAMPLE_W-1:0]  acc_r [8];
  logic signed [SAMPLE_W-1:0]  c_r   [6];
  cplx_t                       t_r;
  cplx_t                       inv_r;
  cplx_t                       d_r;
  logic [MAG_W-1:0]            m_r;
  logic [QUO_W-1:0]            qre_r;
  logic                        out_valid_r;
  logic [TDATA_W-1:0]          out_data_r;
  logic                        out_user_r;

  logic                        in_acc;
  cmul_ctrl_t                  mul_ctrl;
  cplx_t                       mul_x;
  cplx_t                       mul_y;
  cplx_t                       op_x;
  cplx_t                       op_y;
  logic                        mul_done;
  cplx_t                       mul_p;
  logic [MAG_W-1:0]            mul_mag;
  logic                        div_start;
  logic [INNER_W-1:0]          div_num;
  logic                        div_done;
  logic [QUO_W-1:0]            div_quo;
  cplx_t                       a11, a12, a21, a22, b11, b12, b21, b22;
  logic signed [INNER_W-1:0]   den_re;
  logic signed [INNER_W-1:0]   den_im;
  logic signed [INNER_W-1:0]   qre_s;
  logic signed [INNER_W-1:0]   qim_s;
  logic signed [SAMPLE_W-1:0]  c11_re, c11_im, c22_re, c22_im;

  function automatic cplx_t to_cplx(input logic signed [SAMPLE_W-1:0] re,
                                    input logic signed [SAMPLE_W-1:0] im);
    cplx_t r;
    r.re = {{(INNER_W-SAMPLE_W){re[SAMPLE_W-1]}}, re};
    r.im = {{(INNER_W-SAMPLE_W){im[SAMPLE_W-1]}}, im};
    return r;
  endfunction

  function automatic logic signed [INNER_W:0] ext1(input logic signed [INNER_W-1:0] v);
    return {v[INNER_W-1], v};
  endfunction

  assign a11 = to_cplx(acc_r[0], acc_r[1]);
  assign a12 = to_cplx(acc_r[2], acc_r[3]);
  assign a21 = to_cplx(acc_r[4], acc_r[5]);
  assign a22 = to_cplx(acc_r[6], acc_r[7]);
  assign b11 = to_cplx(b_r[0], b_r[1]);
  assign b12 = to_cplx(b_r[2], b_r[3]);
  assign b21 = to_cplx(b_r[4], b_r[5]);
  assign b22 = to_cplx(b_r[6], b_r[7]);

  // Operand schedule of the star product chains
  always_comb begin
    case (op_r)
      OP_PRE: begin op_x = a22; op_y = b11;   end
      OP_T1:  begin op_x = a12; op_y = b11;   end
      OP_T2:  begin op_x = t_r; op_y = a21;   end
      OP_C11: begin op_x = t_r; op_y = inv_r; end
      OP_T4:  begin op_x = a12; op_y = b12;   end
      OP_C12: begin op_x = t_r; op_y = inv_r; end
      OP_T6:  begin op_x = a21; op_y = b21;   end
      OP_C21: begin op_x = t_r; op_y = inv_r; end
      OP_T8:  begin op_x = b21; op_y = a22;   end
      OP_T9:  begin op_x = t_r; op_y = b12;   end
      default: begin op_x = t_r; op_y = inv_r; end
    endcase
  end

  // Drive the shared units
  always_comb begin
    mul_ctrl.start    = (state_r == ST_MUL_GO) || (state_r == ST_MAG_GO);
    mul_ctrl.mag_mode = (state_r == ST_MAG_GO);
    if (state_r inside {ST_MAG_GO, ST_MAG_WAIT}) begin
      mul_x = d_r;
      mul_y = d_r;
    end else begin
      mul_x = op_x;
      mul_y = op_y;
    end
  end

  assign div_start = (state_r == ST_DIV_GO);
  assign div_num   = div_im_r ? (d_r.im[INNER_W-1] ? INNER_W'(-d_r.im) : INNER_W'(d_r.im))
                              : (d_r.re[INNER_W-1] ? INNER_W'(-d_r.re) : INNER_W'(d_r.re));

  sps_cmul u_cmul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mul_ctrl),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .p     (mul_p),
    .mag   (mul_mag)
  );

  sps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (m_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Denominator, reciprocal signs and final sums
  assign den_re = sat_inner(ONE_ACC - {{(ACC_W-INNER_W){mul_p.re[INNER_W-1]}}, mul_p.re});
  assign den_im = sat_inner(-{{(ACC_W-INNER_W){mul_p.im[INNER_W-1]}}, mul_p.im});
  assign qre_s  = {1'b0, qre_r};
  assign qim_s  = {1'b0, div_quo};
  assign c11_re = sat_sample(ext1(a11.re) + ext1(mul_p.re));
  assign c11_im = sat_sample(ext1(a11.im) + ext1(mul_p.im));
  assign c22_re = sat_sample(ext1(b22.re) + ext1(mul_p.re));
  assign c22_im = sat_sample(ext1(b22.im) + ext1(mul_p.im));

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_PRE;
      last_r      <= 1'b0;
      sing_r      <= 1'b0;
      div_im_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) acc_r[i] <= (i == 2 || i == 4) ? ONE_SAMPLE : '0;
    end else begin
      // Drop the result once taken, unless the emit step reloads it
      if (out_valid_r && out_tready && state_r != ST_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            for (int i = 0; i < 8; i++) b_r[i] <= in_tdata[i*SAMPLE_W +: SAMPLE_W];
            last_r <= in_tlast;
            op_r   <= OP_PRE;
            if (in_tuser) begin
              for (int i = 0; i < 8; i++) acc_r[i] <= (i == 2 || i == 4) ? ONE_SAMPLE : '0;
              sing_r <= 1'b0;
            end
            state_r <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: state_r <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (op_r)
              OP_PRE: begin
                d_r.re <= den_re;
                d_r.im <= den_im;
              end
              OP_C11: begin c_r[0] <= c11_re; c_r[1] <= c11_im; end
              OP_C12: begin
                c_r[2] <= sat_sample(ext1(mul_p.re));
                c_r[3] <= sat_sample(ext1(mul_p.im));
              end
              OP_C21: begin
                c_r[4] <= sat_sample(ext1(mul_p.re));
                c_r[5] <= sat_sample(ext1(mul_p.im));
              end
              OP_C22: begin
                for (int i = 0; i < 6; i++) acc_r[i] <= c_r[i];
                acc_r[6] <= c22_re;
                acc_r[7] <= c22_im;
              end
              default: t_r <= mul_p;
            endcase
            // Advance the schedule
            if (op_r == OP_PRE) begin
              if (den_re == '0 && den_im == '0) begin
                inv_r.re <= INNER_MAX;
                inv_r.im <= '0;
                sing_r   <= 1'b1;
                op_r     <= OP_T1;
                state_r  <= ST_MUL_GO;
              end else begin
                state_r <= ST_MAG_GO;
              end
            end else if (op_r == OP_C22) begin
              state_r <= last_r ? ST_EMIT : ST_IDLE;
            end else begin
              op_r    <= op_r + 4'd1;
              state_r <= ST_MUL_GO;
            end
          end
        end
        ST_MAG_GO: state_r <= ST_MAG_WAIT;
        ST_MAG_WAIT: begin
          if (mul_done) begin
            m_r      <= mul_mag;
            div_im_r <= 1'b0;
            state_r  <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (!div_im_r) begin
              qre_r    <= div_quo;
              div_im_r <= 1'b1;
              state_r  <= ST_DIV_GO;
            end else begin
              inv_r.re <= d_r.re[INNER_W-1] ? -qre_s : qre_s;
              inv_r.im <= d_r.im[INNER_W-1] ? qim_s : -qim_s;
              op_r     <= OP_T1;
              state_r  <= ST_MUL_GO;
            end
          end
        end
        ST_EMIT: begin
          // Hold until the output register is free
          if (!out_valid_r || out_tready) begin
            for (int i = 0; i < 8; i++) out_data_r[i*SAMPLE_W +: SAMPLE_W] <= acc_r[i];
            out_user_r  <= sing_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_restart_loads_through: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (acc_r[2] == ONE_SAMPLE && acc_r[4] == ONE_SAMPLE && !sing_r))
    else $error("restart did not load the through connection");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_div_nonzero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_GO) |-> (m_r != '0))
    else $error("division started with a zero magnitude");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL_WAIT || state_r == ST_MAG_WAIT))
    else $error("multiplier result arrived outside a wait step");
`endif

endmodule

### tb/sv/tb_s_parameter_cascade_star.sv
// Testbench for the S-parameter star-product cascade: directed and random stages.
`timescale 1ns / 1ps

module tb_s_parameter_cascade_star import sps_pkg::*; ();

  localparam int LIMIT_CYCLES = 6000000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic signed [SAMPLE_W-1:0] UNITY = 16'sd16384;

  typedef struct {
    longint re;
    longint im;
  } zval_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] w [8];
    logic                       singular;
  } cascade_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;   // s11_re, s11_im, s12_re, s12_im, s21_re, s21_im, s22_re, s22_im
  logic               in_tuser;   // first_stage
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;  // c11_re, c11_im, c12_re, c12_im, c21_re, c21_im, c22_re, c22_im
  logic               out_tuser;  // near_singular

  cascade_t expected_matrices [$];
  longint   acc_model [8];
  bit       singular_model;
  int       errors;
  int       cycle_count;
  int       gap_pct;
  int       stall_pct;
  int       stall_left;

  string field_names [8] = '{"c11_re", "c11_im", "c12_re", "c12_im",
                             "c21_re", "c21_im", "c22_re", "c22_im"};

  s_parameter_cascade_star u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Cascade arithmetic
  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Round half up to the fraction grid
  function automatic longint round_q(longint x);
    return (x + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic zval_t zmul(zval_t a, zval_t b);
    zval_t r;
    r.re = clamp(round_q(a.re * b.re) - round_q(a.im * b.im), INNER_W);
    r.im = clamp(round_q(a.re * b.im) + round_q(a.im * b.re), INNER_W);
    return r;
  endfunction

  function automatic longint quot_sat(longint mag, bit [63:0] m);
    bit [63:0] q;
    q = ($unsigned(mag) << (2 * FRAC_BITS)) / m;
    if (q > 64'h7fff_ffff) return 64'h7fff_ffff;
    return longint'(q);
  endfunction

  function automatic zval_t acc_pair(int k);
    zval_t c;
    c.re = acc_model[2 * k];
    c.im = acc_model[2 * k + 1];
    return c;
  endfunction

  function automatic void load_through();
    foreach (acc_model[i]) acc_model[i] = 0;
    acc_model[2] = clamp(longint'(1) <<< FRAC_BITS, SAMPLE_W);
    acc_model[4] = acc_model[2];
  endfunction

  // Combine one stage into the cascade; return 1 when a matrix goes out
  function automatic bit combine_stage(logic [TDATA_W-1:0] data, bit first, bit last,
                                       output cascade_t res);
    zval_t     b [4];
    zval_t     c [4];
    zval_t     a11, a12, a21, a22, p, d, inv;
    bit [63:0] m;
    for (int k = 0; k < 4; k++) begin
      b[k].re = longint'($signed(data[32 * k +: 16]));
      b[k].im = longint'($signed(data[32 * k + 16 +: 16]));
    end
    if (first) begin
      load_through();
      singular_model = 1'b0;
    end
    a11 = acc_pair(0);
    a12 = acc_pair(1);
    a21 = acc_pair(2);
    a22 = acc_pair(3);
    p = zmul(a22, b[0]);
    d.re = clamp((longint'(1) <<< FRAC_BITS) - p.re, INNER_W);
    d.im = clamp(-p.im, INNER_W);
    if (d.re == 0 && d.im == 0) begin
      singular_model = 1'b1;
      inv.re = 64'h7fff_ffff;
      inv.im = 0;
    end else begin
      m = $unsigned(d.re * d.re) + $unsigned(d.im * d.im);
      inv.re = quot_sat(d.re < 0 ? -d.re : d.re, m);
      inv.im = quot_sat(d.im < 0 ? -d.im : d.im, m);
      if (d.re < 0) inv.re = -inv.re;
      if (d.im >= 0) inv.im = -inv.im;
    end
    p = zmul(zmul(zmul(a12, b[0]), a21), inv);
    c[0].re = a11.re + p.re;
    c[0].im = a11.im + p.im;
    c[1] = zmul(zmul(a12, b[1]), inv);
    c[2] = zmul(zmul(a21, b[2]), inv);
    p = zmul(zmul(zmul(b[2], a22), b[1]), inv);
    c[3].re = b[3].re + p.re;
    c[3].im = b[3].im + p.im;
    for (int k = 0; k < 4; k++) begin
      acc_model[2 * k]     = clamp(c[k].re, SAMPLE_W);
      acc_model[2 * k + 1] = clamp(c[k].im, SAMPLE_W);
    end
    foreach (res.w[i]) res.w[i] = acc_model[i][SAMPLE_W-1:0];
    res.singular = singular_model;
    return last;
  endfunction

  // Send one stage item; a last stage records its expected matrix
  task automatic send_stage(logic [TDATA_W-1:0] data, bit first, bit last);
    cascade_t res;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (combine_stage(data, first, last, res))
      expected_matrices.insert(expected_matrices.size(), res);
    // hold valid unless a gap is drawn
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(40, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 32767) - 16384);
      2:       return 16'($urandom_range(0, 8000) - 4000);
      default: return 16'($urandom_range(0, 1200) - 600);
    endcase
  endfunction

  function automatic logic [TDATA_W-1:0] rand_stage();
    logic [TDATA_W-1:0] v;
    for (int k = 0; k < 8; k++) v[16 * k +: 16] = rand_word();
    return v;
  endfunction

  function automatic logic [TDATA_W-1:0] all_words(logic [15:0] x);
    return {8{x}};
  endfunction

  // Pair of stages; the second one's denominator is exactly zero
  task automatic send_singular_pair(bit last);
    logic [TDATA_W-1:0] v;
    v = rand_stage();
    v[15:0]    = '0;
    v[31:16]   = '0;
    v[79:64]   = '0;
    v[95:80]   = '0;
    v[111:96]  = UNITY;
    v[127:112] = '0;
    send_stage(v, 1'b1, 1'b0);
    v = rand_stage();
    v[15:0]  = UNITY;
    v[31:16] = '0;
    send_stage(v, 1'b0, last);
  endtask

  // Check each result item
  always @(posedge clk) begin
    cascade_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_matrices.size() == 0) begin
        $error("result item with no expected matrix");
        errors++;
      end else begin
        want = expected_matrices.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (out_tdata[16 * k +: 16] !== want.w[k]) begin
            $error("%s: expected %0d, actual %0d", field_names[k], want.w[k],
                   $signed(out_tdata[16 * k +: 16]));
            errors++;
          end
        end
        if (out_tuser !== want.singular) begin
          $error("near_singular: expected %0d, actual %0d", want.singular, out_tuser);
          errors++;
        end
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 400)
                                                : $urandom_range(1, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_extremes();
    send_stage(all_words(16'h0000), 1'b1, 1'b1);
    send_stage(all_words(16'h7fff), 1'b1, 1'b1);
    send_stage(all_words(16'h8000), 1'b1, 1'b1);
    send_stage(all_words(16'hffff), 1'b1, 1'b1);
    send_stage(all_words(UNITY), 1'b1, 1'b1);
    send_stage({16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 1'b1, 1'b0);
    send_stage(all_words(16'h8000), 1'b0, 1'b1);
  endtask

  task automatic test_singular();
    send_singular_pair(1'b1);
    // flag must persist to the end of the run
    send_stage(rand_stage(), 1'b0, 1'b1);
    send_stage(rand_stage(), 1'b1, 1'b1);
  endtask

  task automatic test_no_restart();
    send_stage(rand_stage(), 1'b1, 1'b0);
    send_stage(rand_stage(), 1'b0, 1'b1);
    send_stage(rand_stage(), 1'b0, 1'b1);
    send_stage(rand_stage(), 1'b0, 1'b0);
    send_stage(rand_stage(), 1'b0, 1'b1);
  endtask

  task automatic test_random(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if (sent > n_items / 2 && sent < n_items / 2 + 8) wait_drained();
      case ($urandom_range(0, 9))
        0: begin
          send_stage(rand_stage(), 1'($urandom), 1'($urandom));
          sent++;
        end
        1: begin
          send_singular_pair(1'($urandom));
          sent += 2;
        end
        default: begin
          len = $urandom_range(1, 5);
          for (int i = 0; i < len; i++)
            send_stage(rand_stage(), i == 0, i == len - 1);
          sent += len;
        end
      endcase
      if ($urandom_range(0, 49) == 0) begin
        gap_pct   = $urandom_range(0, 1) ? 0 : 30;
        stall_pct = $urandom_range(0, 1) ? 0 : 25;
      end
    end
  endtask

  initial begin
    errors      = 0;
    cycle_count = 0;
    gap_pct     = 25;
    stall_pct   = 20;
    stall_left  = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    load_through();
    singular_model = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_singular();
    test_no_restart();
    wait_drained();
    test_random(1780);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_matrices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
